>>> rtl/chip8cpu_pkg.sv
// Shared constants, micro-op codes, control/status types and font table for the CHIP-8 core.
package chip8cpu_pkg;

   localparam int MEM_BYTES   = 4096;
   localparam int MEM_AW      = $clog2(MEM_BYTES);
   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int DISP_W      = 64;
   localparam int DISP_H      = 32;
   localparam int FONT_BYTES  = 80;
   localparam int REQ_W       = 48;
   localparam int RSP_W       = 96;

   localparam logic [11:0] START_PC = 12'h200;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_ROW   = 2'd2;

   localparam logic [15:0] OP_CLS   = 16'h00E0;
   localparam logic [15:0] OP_RET   = 16'h00EE;
   localparam logic [7:0]  KEY_DOWN = 8'h9E;
   localparam logic [7:0]  KEY_UP   = 8'hA1;
   localparam logic [7:0]  FX_GETDT = 8'h07;
   localparam logic [7:0]  FX_SETDT = 8'h15;
   localparam logic [7:0]  FX_SETST = 8'h18;
   localparam logic [7:0]  FX_ADDI  = 8'h1E;
   localparam logic [7:0]  FX_FONT  = 8'h29;
   localparam logic [7:0]  FX_BCD   = 8'h33;
   localparam logic [7:0]  FX_STORE = 8'h55;
   localparam logic [7:0]  FX_LOAD  = 8'h65;

   localparam logic [4:0] U_NONE      = 5'd0;
   localparam logic [4:0] U_CLEAR     = 5'd1;
   localparam logic [4:0] U_LATCH     = 5'd2;
   localparam logic [4:0] U_MEMWR     = 5'd3;
   localparam logic [4:0] U_FETCH_HI  = 5'd4;
   localparam logic [4:0] U_FETCH_LO  = 5'd5;
   localparam logic [4:0] U_FETCH_END = 5'd6;
   localparam logic [4:0] U_RDX       = 5'd7;
   localparam logic [4:0] U_RDY       = 5'd8;
   localparam logic [4:0] U_EXEC      = 5'd9;
   localparam logic [4:0] U_DRAW_RD   = 5'd10;
   localparam logic [4:0] U_DRAW_WR   = 5'd11;
   localparam logic [4:0] U_DRAW_END  = 5'd12;
   localparam logic [4:0] U_BCD       = 5'd13;
   localparam logic [4:0] U_STORE     = 5'd14;
   localparam logic [4:0] U_LOAD_RD   = 5'd15;
   localparam logic [4:0] U_LOAD_WR   = 5'd16;
   localparam logic [4:0] U_TICK      = 5'd17;
   localparam logic [4:0] U_OUT       = 5'd18;

   typedef struct packed {
      logic [4:0] uop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [3:0] op_class;
      logic [7:0] nn;
      logic       n_zero;
      logic       draw_last;
      logic       x_last;
      logic       bcd_last;
   } status_type;

   localparam logic [7:0] FONT [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

endpackage

>>> rtl/chip8_cpu_core_top.sv
// Top level of the CHIP-8 core: sequencer plus datapath behind one request and one response stream.
//
// Each request word carries a command: write a memory byte, execute one
// instruction, read one display row, or no operation. Each request yields
// exactly one response word with the program counter, the executed opcode,
// the display row, and the redraw and beep flags.
// A read row or no-op goes straight to the response, and a memory write adds one write step.
// An instruction runs fetch high, fetch low, fetch end, read X, read Y, execute and timer tick.
// Sprite draw adds a memory read and a display write per drawn sprite line (up to 15) plus a
// draw-end step, BCD writes three digits, register store writes V0..Vx and register load
// reads and writes V0..Vx. One request is in flight at a time and the next one can be
// accepted in the cycle after the response word is loaded. After reset the core runs a pass
// that writes all 4096 main memory bytes, loading the font and clearing the rest; req_tready
// stays low until it ends. A response is held in an output register while rsp_tready is low;
// the next request is still accepted and runs, and its result waits until the held word is taken.
module chip8_cpu_core_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], address[13:2], data[21:14], keys[37:22], random_byte[45:38]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pc[11:0], opcode[27:12], row_pixels[91:28], redraw[92], beep[93]
   output logic [95:0] rsp_tdata
);
   import chip8cpu_pkg::*;

   ctrl_cmd_type cmd;
   status_type   status;

   chip8cpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tdata[1:0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   chip8cpu_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> rtl/chip8cpu_ctrl.sv
// CHIP-8 sequencing FSM: one micro-op per cycle, U_NONE while idle or held.
module chip8cpu_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic [1:0]                 req_cmd,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  chip8cpu_pkg::status_type   status,
   output chip8cpu_pkg::ctrl_cmd_type cmd
);
   import chip8cpu_pkg::*;

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_MEMWR = 5'd2;
   localparam logic [4:0] S_F1    = 5'd3;
   localparam logic [4:0] S_F2    = 5'd4;
   localparam logic [4:0] S_F3    = 5'd5;
   localparam logic [4:0] S_RX    = 5'd6;
   localparam logic [4:0] S_RY    = 5'd7;
   localparam logic [4:0] S_EXEC  = 5'd8;
   localparam logic [4:0] S_DRD   = 5'd9;
   localparam logic [4:0] S_DWR   = 5'd10;
   localparam logic [4:0] S_DEND  = 5'd11;
   localparam logic [4:0] S_BCD   = 5'd12;
   localparam logic [4:0] S_STORE = 5'd13;
   localparam logic [4:0] S_LRD   = 5'd14;
   localparam logic [4:0] S_LWR   = 5'd15;
   localparam logic [4:0] S_TICK  = 5'd16;
   localparam logic [4:0] S_DONE  = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       fire;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign fire       = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd.uop  = U_NONE;
      valid_in = valid_ff && !rsp_tready;
      case (state_ff)
         S_CLEAR: begin
            cmd.uop = U_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.uop = U_LATCH;
               case (req_cmd)
                  CMD_WRITE: state_in = S_MEMWR;
                  CMD_EXEC:  state_in = S_F1;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_MEMWR: begin
            cmd.uop  = U_MEMWR;
            state_in = S_DONE;
         end
         S_F1: begin
            cmd.uop  = U_FETCH_HI;
            state_in = S_F2;
         end
         S_F2: begin
            cmd.uop  = U_FETCH_LO;
            state_in = S_F3;
         end
         S_F3: begin
            cmd.uop  = U_FETCH_END;
            state_in = S_RX;
         end
         S_RX: begin
            cmd.uop  = U_RDX;
            state_in = S_RY;
         end
         S_RY: begin
            cmd.uop  = U_RDY;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.uop  = U_EXEC;
            state_in = S_TICK;
            if (status.op_class == 4'hD) begin
               state_in = status.n_zero ? S_DEND : S_DRD;
            end else if (status.op_class == 4'hF) begin
               if (status.nn == FX_BCD) state_in = S_BCD;
               else if (status.nn == FX_STORE) state_in = S_STORE;
               else if (status.nn == FX_LOAD) state_in = S_LRD;
            end
         end
         S_DRD: begin
            cmd.uop  = U_DRAW_RD;
            state_in = S_DWR;
         end
         S_DWR: begin
            cmd.uop  = U_DRAW_WR;
            state_in = status.draw_last ? S_DEND : S_DRD;
         end
         S_DEND: begin
            cmd.uop  = U_DRAW_END;
            state_in = S_TICK;
         end
         S_BCD: begin
            cmd.uop = U_BCD;
            if (status.bcd_last) state_in = S_TICK;
         end
         S_STORE: begin
            cmd.uop = U_STORE;
            if (status.x_last) state_in = S_TICK;
         end
         S_LRD: begin
            cmd.uop  = U_LOAD_RD;
            state_in = S_LWR;
         end
         S_LWR: begin
            cmd.uop  = U_LOAD_WR;
            state_in = status.x_last ? S_TICK : S_LRD;
         end
         S_TICK: begin
            cmd.uop  = U_TICK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (fire) begin
               cmd.uop  = U_OUT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> rtl/chip8cpu_dpath.sv
// Datapath of the CHIP-8 core: memory, display, registers, stack, timers and result word.
module chip8cpu_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  chip8cpu_pkg::ctrl_cmd_type       cmd,
   output chip8cpu_pkg::status_type         status,
   input  logic [chip8cpu_pkg::REQ_W-1:0]   req_tdata,
   output logic [chip8cpu_pkg::RSP_W-1:0]   rsp_tdata
);
   import chip8cpu_pkg::*;

   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  mem_rdata_ff;
   logic [MEM_AW-1:0] mem_raddr, mem_waddr;
   logic [7:0]  mem_wdata;
   logic        mem_we;

   logic [DISP_W-1:0] frame_ff [DISP_H];
   logic [7:0]  regs_ff [16];
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [SP_W-1:0] sp_ff, sp_dec, sp_inc;
   logic [11:0] pc_ff;
   logic [15:0] index_ff;
   logic [7:0]  delay_ff, sound_ff;
   logic [MEM_AW-1:0] clr_ff;

   logic [1:0]  cmd_ff;
   logic [11:0] addr_ff;
   logic [7:0]  data_ff, rnd_ff;
   logic [15:0] keys_ff;
   logic [15:0] op_ff;
   logic [7:0]  vx_ff, vy_ff;
   logic [3:0]  cnt_ff;
   logic        hit_ff, redraw_ff, beep_ff;
   logic [93:0] rsp_ff;

   logic [3:0]  op_x, op_y, op_n, reg_raddr;
   logic [7:0]  op_nn, reg_rd;
   logic [MEM_AW-1:0] ea;
   logic [5:0]  draw_row;
   logic [4:0]  frame_raddr;
   logic [DISP_W-1:0] frame_rd, sprite, row_out;
   logic [7:0]  bcd_h, bcd_t, bcd_o, bcd_dig;
   logic [6:0]  bcd_r;
   logic [14:0] bcd_m;
   logic [8:0]  sum9;
   logic [7:0]  alu_res;
   logic        alu_flag, alu_we;
   logic        exec_we, flag_we, skip;
   logic [7:0]  exec_wdata;

   assign op_x  = op_ff[11:8];
   assign op_y  = op_ff[7:4];
   assign op_n  = op_ff[3:0];
   assign op_nn = op_ff[7:0];

   always_comb begin
      case (cmd.uop)
         U_RDX:   reg_raddr = op_x;
         U_RDY:   reg_raddr = op_y;
         default: reg_raddr = cnt_ff;
      endcase
   end
   assign reg_rd = regs_ff[reg_raddr];

   assign ea = index_ff[MEM_AW-1:0] + MEM_AW'(cnt_ff);

   // BCD digits by compare and reciprocal multiply
   always_comb begin
      if (vx_ff >= 8'd200) bcd_h = 8'd2;
      else if (vx_ff >= 8'd100) bcd_h = 8'd1;
      else bcd_h = 8'd0;
      bcd_r = 7'(vx_ff - 8'(bcd_h * 8'd100));
      bcd_m = 15'(bcd_r) * 15'd205;
      bcd_t = 8'(bcd_m[14:11]);
      bcd_o = 8'(bcd_r) - 8'(bcd_t * 8'd10);
      case (cnt_ff[1:0])
         2'd0:    bcd_dig = bcd_h;
         2'd1:    bcd_dig = bcd_t;
         default: bcd_dig = bcd_o;
      endcase
   end

   always_comb begin
      case (cmd.uop)
         U_FETCH_HI: mem_raddr = pc_ff;
         U_FETCH_LO: mem_raddr = pc_ff + 12'd1;
         default:    mem_raddr = ea;
      endcase
      mem_we    = 1'b0;
      mem_waddr = ea;
      mem_wdata = reg_rd;
      case (cmd.uop)
         U_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff < MEM_AW'(FONT_BYTES)) ? FONT[clr_ff[6:0]] : 8'd0;
         end
         U_MEMWR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = data_ff;
         end
         U_BCD: begin
            mem_we    = 1'b1;
            mem_wdata = bcd_dig;
         end
         U_STORE: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   assign draw_row    = 6'(vy_ff[4:0]) + 6'(cnt_ff);
   assign frame_raddr = (cmd.uop == U_OUT) ? addr_ff[4:0] : draw_row[4:0];
   assign frame_rd    = frame_ff[frame_raddr];
   assign sprite      = {mem_rdata_ff, 56'd0} >> vx_ff[5:0];
   assign row_out     = (cmd_ff == CMD_ROW && addr_ff[11:5] == 7'd0) ? frame_rd : '0;

   always_ff @(posedge clock) begin
      if (reset || (cmd.uop == U_EXEC && op_ff == OP_CLS)) begin
         for (int i = 0; i < DISP_H; i++) frame_ff[i] <= '0;
      end else if (cmd.uop == U_DRAW_WR) begin
         frame_ff[draw_row[4:0]] <= frame_rd ^ sprite;
      end
   end

   always_comb begin
      sum9     = {1'b0, vx_ff} + {1'b0, vy_ff};
      alu_res  = vy_ff;
      alu_flag = 1'b0;
      alu_we   = 1'b1;
      flag_we  = 1'b0;
      case (op_n)
         4'h0: alu_res = vy_ff;
         4'h1: alu_res = vx_ff | vy_ff;
         4'h2: alu_res = vx_ff & vy_ff;
         4'h3: alu_res = vx_ff ^ vy_ff;
         4'h4: begin
            alu_res = sum9[7:0]; alu_flag = sum9[8]; flag_we = 1'b1;
         end
         4'h5: begin
            alu_res = vx_ff - vy_ff; alu_flag = (vx_ff >= vy_ff); flag_we = 1'b1;
         end
         4'h6: begin
            alu_res = vx_ff >> 1; alu_flag = vx_ff[0]; flag_we = 1'b1;
         end
         4'h7: begin
            alu_res = vy_ff - vx_ff; alu_flag = (vy_ff >= vx_ff); flag_we = 1'b1;
         end
         4'hE: begin
            alu_res = vx_ff << 1; alu_flag = vx_ff[7]; flag_we = 1'b1;
         end
         default: alu_we = 1'b0;
      endcase

      exec_we    = 1'b1;
      exec_wdata = op_nn;
      skip       = 1'b0;
      case (op_ff[15:12])
         4'h3: begin exec_we = 1'b0; skip = (vx_ff == op_nn); end
         4'h4: begin exec_we = 1'b0; skip = (vx_ff != op_nn); end
         4'h5: begin exec_we = 1'b0; skip = (vx_ff == vy_ff); end
         4'h9: begin exec_we = 1'b0; skip = (vx_ff != vy_ff); end
         4'hE: begin
            exec_we = 1'b0;
            skip = (op_nn == KEY_DOWN && keys_ff[vx_ff[3:0]]) ||
                   (op_nn == KEY_UP && !keys_ff[vx_ff[3:0]]);
         end
         4'h6: exec_wdata = op_nn;
         4'h7: exec_wdata = vx_ff + op_nn;
         4'h8: begin exec_we = alu_we; exec_wdata = alu_res; end
         4'hC: exec_wdata = rnd_ff & op_nn;
         4'hF: begin exec_we = (op_nn == FX_GETDT); exec_wdata = delay_ff; end
         default: exec_we = 1'b0;
      endcase
      if (op_ff[15:12] != 4'h8) flag_we = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= 8'd0;
      end else begin
         case (cmd.uop)
            U_EXEC: begin
               // flag wins over the result when X is F
               if (exec_we && !(flag_we && op_x == 4'hF)) regs_ff[op_x] <= exec_wdata;
               if (flag_we) regs_ff[15] <= {7'd0, alu_flag};
            end
            U_DRAW_END: regs_ff[15] <= {7'd0, hit_ff};
            U_LOAD_WR:  regs_ff[cnt_ff] <= mem_rdata_ff;
            default: ;
         endcase
      end
   end

   assign sp_dec = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;
   assign sp_inc = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 12'd0;
         sp_ff    <= '0;
         pc_ff    <= START_PC;
         index_ff <= 16'd0;
         delay_ff <= 8'd0;
         sound_ff <= 8'd0;
         clr_ff   <= '0;
      end else begin
         case (cmd.uop)
            U_CLEAR:     clr_ff <= clr_ff + 1'b1;
            U_FETCH_END: pc_ff <= pc_ff + 12'd2;
            U_EXEC: begin
               if (skip) pc_ff <= pc_ff + 12'd2;
               case (op_ff[15:12])
                  4'h0: begin
                     if (op_ff == OP_RET) begin
                        sp_ff <= sp_dec;
                        pc_ff <= stack_ff[sp_dec];
                     end
                  end
                  4'h1: pc_ff <= op_ff[11:0];
                  4'h2: begin
                     stack_ff[sp_ff] <= pc_ff;
                     sp_ff <= sp_inc;
                     pc_ff <= op_ff[11:0];
                  end
                  4'hA: index_ff <= {4'd0, op_ff[11:0]};
                  4'hF: begin
                     case (op_nn)
                        FX_SETDT: delay_ff <= vx_ff;
                        FX_SETST: sound_ff <= vx_ff;
                        FX_ADDI:  index_ff <= index_ff + 16'(vx_ff);
                        FX_FONT:  index_ff <= 16'({vx_ff, 2'b00}) + 16'(vx_ff);
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
            U_TICK: begin
               if (delay_ff != 8'd0) delay_ff <= delay_ff - 8'd1;
               if (sound_ff != 8'd0) sound_ff <= sound_ff - 8'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.uop)
         U_LATCH: begin
            cmd_ff    <= req_tdata[1:0];
            addr_ff   <= req_tdata[13:2];
            data_ff   <= req_tdata[21:14];
            keys_ff   <= req_tdata[37:22];
            rnd_ff    <= req_tdata[45:38];
            redraw_ff <= 1'b0;
            beep_ff   <= 1'b0;
         end
         U_FETCH_LO:  op_ff[15:8] <= mem_rdata_ff;
         U_FETCH_END: op_ff[7:0] <= mem_rdata_ff;
         U_RDX:       vx_ff <= reg_rd;
         U_RDY: begin
            vy_ff  <= reg_rd;
            cnt_ff <= 4'd0;
            hit_ff <= 1'b0;
         end
         U_EXEC: begin
            if (op_ff == OP_CLS || op_ff[15:12] == 4'hD) redraw_ff <= 1'b1;
         end
         U_DRAW_WR: begin
            if ((frame_rd & sprite) != '0) hit_ff <= 1'b1;
            cnt_ff <= cnt_ff + 4'd1;
         end
         U_BCD, U_STORE, U_LOAD_WR: cnt_ff <= cnt_ff + 4'd1;
         U_TICK:      beep_ff <= (sound_ff == 8'd1);
         U_OUT: begin
            rsp_ff <= {beep_ff, redraw_ff, row_out,
                       (cmd_ff == CMD_EXEC) ? op_ff : 16'd0, pc_ff};
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {2'b00, rsp_ff};

   assign status.clear_last = (clr_ff == MEM_AW'(MEM_BYTES - 1));
   assign status.op_class   = op_ff[15:12];
   assign status.nn         = op_nn;
   assign status.n_zero     = (op_n == 4'd0);
   assign status.draw_last  = (5'(cnt_ff) + 5'd1 == 5'(op_n)) || (draw_row + 6'd1 >= 6'(DISP_H));
   assign status.x_last     = (cnt_ff == op_x);
   assign status.bcd_last   = (cnt_ff == 4'd2);

endmodule
